// ===== rtl/psvs_pkg.sv =====
// psvs_pkg: types, constants and helper functions of the packed sub-word vector store
// used by psvs_cfg, psvs_ctrl and the top level; no other dependencies
package psvs_pkg;

  // storage geometry
  localparam int STORE_WORDS = 1024;
  localparam int WORD_BITS   = 32;
  localparam int WORD_LG     = $clog2(WORD_BITS);
  localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CNT_W       = $clog2(STORE_WORDS + 1);

  // field widths
  localparam int VAL_W   = 17;
  localparam int ELEM_W  = 16;
  localparam int INDEX_W = 15;
  localparam int COUNT_W = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [1:0] REG_IS_SIGNED   = 2'd1;
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_FILL = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]         width_log2;
    logic               is_signed;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } ram_req_t;

  // width codes above 16 bits saturate
  function automatic logic [2:0] elem_lg(logic [2:0] code);
    elem_lg = (code > 3'd4) ? 3'd4 : code;
  endfunction

  // element bit count
  function automatic logic [4:0] elem_bits(logic [2:0] lg);
    elem_bits = 5'd1 << lg;
  endfunction

  // low mask of one element
  function automatic logic [ELEM_W-1:0] elem_mask(logic [2:0] lg);
    elem_mask = {ELEM_W{1'b1}} >> (5'd16 - elem_bits(lg));
  endfunction

  // range check of a write or fill value against the element type
  function automatic logic value_fits(logic signed [VAL_W-1:0] v, logic [2:0] lg,
                                      logic sgn);
    logic signed [VAL_W-1:0] hi;
    if (sgn) begin
      hi = v >>> (elem_bits(lg) - 5'd1);
      value_fits = (hi == '0) || (&hi);
    end else begin
      hi = v >>> elem_bits(lg);
      value_fits = (hi == '0);
    end
  endfunction

  // sign-extend an extracted element when the vector is signed
  function automatic logic [VAL_W-1:0] elem_sext(logic [ELEM_W-1:0] e, logic [2:0] lg,
                                                 logic sgn);
    logic neg;
    neg = sgn & e[4'(elem_bits(lg) - 5'd1)];
    elem_sext = neg ? ({1'b0, e} | ~{1'b0, elem_mask(lg)}) : {1'b0, e};
  endfunction

  // replicate the masked value into every slot of a word
  function automatic logic [WORD_BITS-1:0] replicate_elem(logic [ELEM_W-1:0] v,
                                                          logic [2:0] lg);
    logic [WORD_BITS-1:0] fw;
    logic [3:0]           sel;
    for (int b = 0; b < WORD_BITS; b++) begin
      sel   = 4'(b) & 4'(elem_bits(lg) - 5'd1);
      fw[b] = v[sel];
    end
    replicate_elem = fw;
  endfunction

endpackage

// ===== rtl/psvs_ram.sv =====
// psvs_ram: generic single-port synchronous ram, read-first, registered read
// no dependencies
module psvs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/psvs_cfg.sv =====
// psvs_cfg: apb configuration registers (width code, signedness, entry count)
// depends on psvs_pkg
module psvs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psvs_pkg::PADDR_W-1:0]   paddr,
  input  logic [psvs_pkg::PDATA_W-1:0]   pwdata,
  output logic [psvs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output psvs_pkg::cfg_t                 cfg_o
);
  import psvs_pkg::*;

  logic [2:0]         width_log2_q;
  logic               is_signed_q;
  logic [COUNT_W-1:0] entry_count_q;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= 3'd3;
      is_signed_q   <= 1'b0;
      entry_count_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH_LOG2:  width_log2_q  <= pwdata[2:0];
        REG_IS_SIGNED:   is_signed_q   <= pwdata[0];
        REG_ENTRY_COUNT: entry_count_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_WIDTH_LOG2:  prdata = PDATA_W'(width_log2_q);
      REG_IS_SIGNED:   prdata = PDATA_W'(is_signed_q);
      REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = '{width_log2: width_log2_q, is_signed: is_signed_q,
                   entry_count: entry_count_q};

endmodule

// ===== rtl/psvs_ctrl.sv =====
// psvs_ctrl: command sequencer, element extract/insert and fill walker
// depends on psvs_pkg; drives the word ram through a ram_req_t
module psvs_ctrl (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  psvs_pkg::cfg_t                          cfg_i,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              action_i,
  input  logic [psvs_pkg::INDEX_W-1:0]            index_i,
  input  logic signed [psvs_pkg::VAL_W-1:0]       value_i,
  output logic                                    done_o,
  output logic signed [psvs_pkg::VAL_W-1:0]       read_value_o,
  output logic [1:0]                              status_o,
  output psvs_pkg::ram_req_t                      ram_req_o,
  input  logic [psvs_pkg::WORD_BITS-1:0]          ram_rdata_i
);
  import psvs_pkg::*;

  state_e state_q, state_d;

  // command decode at the accepting edge
  action_e              act;
  logic [2:0]           lg_in;
  logic [WORD_LG-1:0]   slot_max;
  logic [WORD_LG-1:0]   slot_pos;
  logic [WORD_LG-1:0]   shift_in;
  logic [INDEX_W-1:0]   word_idx;
  logic                 fits;
  logic                 idx_bad;
  logic [16:0]          used_sum;
  logic [16:0]          used_raw;
  logic [CNT_W-1:0]     used_cap;
  logic                 accept;

  // latched item
  action_e              action_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [WORD_LG-1:0]   shift_q;
  logic [2:0]           lg_q;
  logic                 sgn_q;
  logic [VAL_W-1:0]     value_q;
  logic [CNT_W-1:0]     used_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WORD_BITS-1:0] fw_q;

  // read-modify-write datapath
  logic [WORD_BITS-1:0] slot_mask;
  logic [WORD_BITS-1:0] shifted;
  logic [ELEM_W-1:0]    elem;
  logic [WORD_BITS-1:0] merged;
  logic                 fill_last;

  // result register
  logic                 done_q, done_d;
  logic [VAL_W-1:0]     rv_q, rv_d;
  status_e              st_q, st_d;

  assign act      = action_e'(action_i);
  assign accept   = start & (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign lg_in    = elem_lg(cfg_i.width_log2);
  assign slot_max = WORD_LG'((WORD_BITS >> lg_in) - 1);
  assign slot_pos = index_i[WORD_LG-1:0] & slot_max;
  assign shift_in = WORD_LG'((slot_max - slot_pos) << lg_in);
  assign word_idx = index_i >> (3'(WORD_LG) - lg_in);
  assign fits     = value_fits(value_i, lg_in, cfg_i.is_signed);
  assign idx_bad  = ({1'b0, index_i} >= cfg_i.entry_count) ||
                    ({2'b0, word_idx} >= 17'(STORE_WORDS));

  // words touched by a fill, capped at the store size
  assign used_sum = {1'b0, cfg_i.entry_count} + 17'(slot_max);
  assign used_raw = used_sum >> (3'(WORD_LG) - lg_in);
  assign used_cap = (used_raw > 17'(STORE_WORDS)) ? CNT_W'(STORE_WORDS) : CNT_W'(used_raw);

  // element extract and insert on the word read back
  assign slot_mask = WORD_BITS'(elem_mask(lg_q)) << shift_q;
  assign shifted   = ram_rdata_i >> shift_q;
  assign elem      = shifted[ELEM_W-1:0] & elem_mask(lg_q);
  assign merged    = (ram_rdata_i & ~slot_mask) |
                     ((WORD_BITS'(value_q[ELEM_W-1:0]) << shift_q) & slot_mask);
  assign fill_last = (cnt_q == used_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (act)
            ACT_READ:  if (!idx_bad) state_d = S_RD;
            ACT_WRITE: if (fits && !idx_bad) state_d = S_RD;
            ACT_FILL:  if (fits && (used_cap != '0)) state_d = S_FILL;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_RD:    state_d = S_IDLE;
      S_FILL:  if (fill_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory requests and results
  always_comb begin
    ram_req_o = '{we: 1'b0, addr: ADDR_W'(word_idx), wdata: merged};
    done_d    = 1'b0;
    rv_d      = '0;
    st_d      = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (act)
            ACT_READ: begin
              if (idx_bad) begin
                done_d = 1'b1;
                st_d   = ST_INDEX;
              end
            end
            ACT_WRITE: begin
              if (!fits) begin
                done_d = 1'b1;
                st_d   = ST_VALUE;
              end else if (idx_bad) begin
                done_d = 1'b1;
                st_d   = ST_INDEX;
              end
            end
            ACT_FILL: begin
              if (!fits) begin
                done_d = 1'b1;
                st_d   = ST_VALUE;
              end else if (used_cap == '0) begin
                done_d = 1'b1;
                rv_d   = value_i;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_RD: begin
        ram_req_o.addr = addr_q;
        done_d         = 1'b1;
        if (action_q == ACT_WRITE) begin
          ram_req_o.we = 1'b1;
          rv_d         = value_q;
        end else begin
          rv_d = elem_sext(elem, lg_q, sgn_q);
        end
      end
      S_FILL: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = ADDR_W'(cnt_q);
        ram_req_o.wdata = fw_q;
        if (fill_last) begin
          done_d = 1'b1;
          rv_d   = value_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    rv_q <= rv_d;
    st_q <= st_d;
    if (accept) begin
      action_q <= act;
      addr_q   <= ADDR_W'(word_idx);
      shift_q  <= shift_in;
      lg_q     <= lg_in;
      sgn_q    <= cfg_i.is_signed;
      value_q  <= value_i;
      used_q   <= used_cap;
      cnt_q    <= '0;
      fw_q     <= replicate_elem(value_i[ELEM_W-1:0], lg_in);
    end else if (state_q == S_FILL) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

  // checks
  a_rd_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> done_q)
    else $error("word read did not produce a result");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> cnt_q < used_q)
    else $error("fill walker beyond the words in use");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> state_q != S_IDLE)
    else $error("memory written while idle");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (st_q != ST_OK) |-> rv_q == '0)
    else $error("nonzero value with an error status");

endmodule

// ===== rtl/packed_subword_vector_store.sv =====
// Packed sub-word vector store. Elements of 1, 2, 4, 8 or 16 bits, signed or
// unsigned, sit packed in 32-bit words of a 1024-word single-port ram, first
// element in the high bits. A command is taken when start is high and busy is
// low; its result appears on read_value_o/status_o for exactly one cycle with
// done_o, and the receiver cannot hold it off. Timing is set by the one ram port:
// a read or write reads the word, then extracts the element or writes it back;
// a command rejected for value or index range, or an unknown action, needs no
// ram access; a fill writes one word per cycle over ceil(entry_count / elements
// per word) words, capped at 1024 words. Ram contents are undefined after reset;
// read only elements already written or filled. Configuration is written over
// the apb port by the user while the block is idle; the block does not enforce it.
module packed_subword_vector_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic [psvs_pkg::INDEX_W-1:0]        index_i,
  input  logic signed [psvs_pkg::VAL_W-1:0]   value_i,
  output logic                                done_o,
  output logic signed [psvs_pkg::VAL_W-1:0]   read_value_o,
  output logic [1:0]                          status_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psvs_pkg::PADDR_W-1:0]        paddr,
  input  logic [psvs_pkg::PDATA_W-1:0]        pwdata,
  output logic [psvs_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import psvs_pkg::*;

  cfg_t                 cfg;
  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rdata;

  // configuration registers
  psvs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // command sequencer
  psvs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  // packed word store
  psvs_ram #(
    .DEPTH (STORE_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

endmodule
